>>> design/c2i_pkg.sv
// shared types and constants for the col2im accumulate block
// used by the controller, the datapath and the top level; no dependencies
package c2i_pkg;

    // item kinds carried on the input tuser bit
    localparam logic KIND_ACC   = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic [3:0] REG_CHANNELS = 4'd0;
    localparam logic [3:0] REG_HEIGHT   = 4'd1;
    localparam logic [3:0] REG_WIDTH    = 4'd2;
    localparam logic [3:0] REG_FILTER   = 4'd3;
    localparam logic [3:0] REG_STRIDE   = 4'd4;
    localparam logic [3:0] REG_DILATION = 4'd5;
    localparam logic [3:0] REG_PADDING  = 4'd6;
    localparam logic [3:0] REG_OUTPUT   = 4'd7;

    typedef struct packed {
        logic [6:0]  channels;
        logic [7:0]  image_height;
        logic [7:0]  image_width;
        logic [7:0]  filter_dims;
        logic [7:0]  stride_dims;
        logic [7:0]  dilation_dims;
        logic [7:0]  padding_dims;
        logic [15:0] output_dims;
    } t_cfg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr;
        logic take;
        logic acc_map;
        logic acc_base;
        logic acc_addr;
        logic acc_read;
        logic acc_write;
        logic drn_prod;
        logic drn_total;
        logic drn_pick;
        logic drn_read;
        logic drn_emit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        logic out_free;
    } t_sts;

endpackage

>>> design/col2im_dilated_accumulate.sv
// col2im scatter-accumulate with stride, padding and dilation: top level
// the input accepts no new item before the last accumulate or drain item is done;
// a drain steps through product, total, pick and read, then emits its result into
// the output register, waiting while the output is stalled. the image store has
// one read and one write port. synchronous active-low reset; afterwards a clearing
// pass zeroes every store word with the input not ready. configuration is taken always.
// holds the configuration registers; depends on c2i_pkg, c2i_ctrl, c2i_datapath
module col2im_dilated_accumulate import c2i_pkg::*; #(
    parameter int IMAGE_WORDS = 4096,
    parameter int SUM_BITS    = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // col_value
    input  logic                                 s_axis_tuser,  // kind
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((SUM_BITS+7)/8)*8-1:0]        m_axis_tdata,  // image_value
    output logic                                 m_axis_tlast,  // end_of_image
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [3:0]                           i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);

    localparam int OUT_W = ((SUM_BITS + 7) / 8) * 8;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [SUM_BITS-1:0] w_out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channels      <= 7'd1;
            r_cfg.image_height  <= 8'd8;
            r_cfg.image_width   <= 8'd8;
            r_cfg.filter_dims   <= 8'h33;
            r_cfg.stride_dims   <= 8'h11;
            r_cfg.dilation_dims <= 8'h11;
            r_cfg.padding_dims  <= 8'h00;
            r_cfg.output_dims   <= 16'h0101;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CHANNELS: r_cfg.channels      <= i_cfg_data[6:0];
                REG_HEIGHT:   r_cfg.image_height  <= i_cfg_data[7:0];
                REG_WIDTH:    r_cfg.image_width   <= i_cfg_data[7:0];
                REG_FILTER:   r_cfg.filter_dims   <= i_cfg_data[7:0];
                REG_STRIDE:   r_cfg.stride_dims   <= i_cfg_data[7:0];
                REG_DILATION: r_cfg.dilation_dims <= i_cfg_data[7:0];
                REG_PADDING:  r_cfg.padding_dims  <= i_cfg_data[7:0];
                REG_OUTPUT:   r_cfg.output_dims   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    c2i_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    c2i_datapath #(
        .IMAGE_WORDS (IMAGE_WORDS),
        .SUM_BITS    (SUM_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (w_out_data),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'(w_out_data);

`ifndef NO_ASSERTIONS
    // the store is being cleared right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during the clearing pass");

    // one item at a time: an accepted beat closes the input for a while
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after an accepted beat");

    // an accumulate beat never produces a result
    a_acc_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_ACC) && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("result raised by an accumulate beat");
`endif

endmodule

>>> design/c2i_ctrl.sv
// sequencing controller for the col2im accumulate block
// depends on c2i_pkg; drives the datapath through t_cmd and reads t_sts
module c2i_ctrl import c2i_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_MAP   = 4'd2;
    localparam logic [3:0] S_A_BASE  = 4'd3;
    localparam logic [3:0] S_A_ADDR  = 4'd4;
    localparam logic [3:0] S_A_READ  = 4'd5;
    localparam logic [3:0] S_A_WRITE = 4'd6;
    localparam logic [3:0] S_D_PROD  = 4'd7;
    localparam logic [3:0] S_D_TOTAL = 4'd8;
    localparam logic [3:0] S_D_PICK  = 4'd9;
    localparam logic [3:0] S_D_READ  = 4'd10;
    localparam logic [3:0] S_D_EMIT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = (i_in_kind == KIND_DRAIN) ? S_D_PROD : S_A_MAP;
                end
            end
            S_A_MAP: begin
                o_cmd.acc_map = 1'b1;
                n_state       = S_A_BASE;
            end
            S_A_BASE: begin
                o_cmd.acc_base = 1'b1;
                n_state        = S_A_ADDR;
            end
            S_A_ADDR: begin
                o_cmd.acc_addr = 1'b1;
                n_state        = S_A_READ;
            end
            S_A_READ: begin
                o_cmd.acc_read = 1'b1;
                n_state        = S_A_WRITE;
            end
            S_A_WRITE: begin
                o_cmd.acc_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_D_PROD: begin
                o_cmd.drn_prod = 1'b1;
                n_state        = S_D_TOTAL;
            end
            S_D_TOTAL: begin
                o_cmd.drn_total = 1'b1;
                n_state         = S_D_PICK;
            end
            S_D_PICK: begin
                o_cmd.drn_pick = 1'b1;
                n_state        = S_D_READ;
            end
            S_D_READ: begin
                o_cmd.drn_read = 1'b1;
                n_state        = S_D_EMIT;
            end
            S_D_EMIT: begin
                o_cmd.drn_emit = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/c2i_datapath.sv
// datapath of the col2im accumulate block: position counters, address
// arithmetic, image store with read-modify-write, drain pointer, output register
// depends on c2i_pkg
module c2i_datapath import c2i_pkg::*; #(
    parameter int IMAGE_WORDS = 4096,
    parameter int SUM_BITS    = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_out_ready,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    output logic [SUM_BITS-1:0]    o_out_data,
    output logic                   o_out_last
);

    localparam int AW = $clog2(IMAGE_WORDS);
    localparam int PW = $clog2(IMAGE_WORDS + 1);
    localparam int XW = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 1;
    localparam logic signed [XW-1:0] SUM_MAX =
        {{(XW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] SUM_MIN =
        {{(XW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

    // image store
    logic [SUM_BITS-1:0] r_mem [0:IMAGE_WORDS-1];
    logic [SUM_BITS-1:0] r_rd_data;

    // control state
    logic [AW-1:0] r_clr;
    logic [5:0]    r_sc;
    logic [3:0]    r_krow;
    logic [3:0]    r_kcol;
    logic [7:0]    r_orow;
    logic [7:0]    r_ocol;
    logic [PW-1:0] r_ptr;
    logic          r_out_valid;

    // payload
    logic [SAMPLE_BITS-1:0] r_sample;
    logic signed [13:0]     r_row;
    logic signed [13:0]     r_col;
    logic [13:0]            r_chh;
    logic                   r_inr;
    logic [14:0]            r_base;
    logic [23:0]            r_lin;
    logic                   r_hit;
    logic [14:0]            r_cw;
    logic [22:0]            r_total;
    logic [AW-1:0]          r_p;
    logic                   r_end;
    logic [SUM_BITS-1:0]    r_out_data;
    logic                   r_out_last;

    // config fields
    logic [3:0] w_sv, w_sh, w_dv, w_dh, w_pt, w_pl;
    logic [3:0] w_lim_kr, w_lim_kc;
    logic [7:0] w_lim_or, w_lim_oc;
    logic [6:0] w_effc;

    assign w_sv = i_cfg.stride_dims[7:4];
    assign w_sh = i_cfg.stride_dims[3:0];
    assign w_dv = i_cfg.dilation_dims[7:4];
    assign w_dh = i_cfg.dilation_dims[3:0];
    assign w_pt = i_cfg.padding_dims[7:4];
    assign w_pl = i_cfg.padding_dims[3:0];
    assign w_lim_kr = (i_cfg.filter_dims[7:4] == 4'd0) ? 4'd1 : i_cfg.filter_dims[7:4];
    assign w_lim_kc = (i_cfg.filter_dims[3:0] == 4'd0) ? 4'd1 : i_cfg.filter_dims[3:0];
    assign w_lim_or = (i_cfg.output_dims[15:8] == 8'd0) ? 8'd1 : i_cfg.output_dims[15:8];
    assign w_lim_oc = (i_cfg.output_dims[7:0] == 8'd0) ? 8'd1 : i_cfg.output_dims[7:0];

    always_comb begin
        if (i_cfg.channels == 7'd0) begin
            w_effc = 7'd1;
        end else if (i_cfg.channels > 7'd64) begin
            w_effc = 7'd64;
        end else begin
            w_effc = i_cfg.channels;
        end
    end

    // image position of the current element
    logic [11:0]        w_rprod, w_cprod;
    logic [7:0]         w_krprod, w_kcprod;
    logic [12:0]        w_rsum, w_csum;
    logic signed [13:0] w_row, w_col;
    logic [13:0]        w_chh;

    assign w_rprod  = {4'd0, r_orow} * {8'd0, w_sv};
    assign w_cprod  = {4'd0, r_ocol} * {8'd0, w_sh};
    assign w_krprod = {4'd0, r_krow} * {4'd0, w_dv};
    assign w_kcprod = {4'd0, r_kcol} * {4'd0, w_dh};
    assign w_rsum   = {1'b0, w_rprod} + {5'd0, w_krprod};
    assign w_csum   = {1'b0, w_cprod} + {5'd0, w_kcprod};
    assign w_row    = $signed({1'b0, w_rsum}) - $signed({10'd0, w_pt});
    assign w_col    = $signed({1'b0, w_csum}) - $signed({10'd0, w_pl});
    assign w_chh    = {8'd0, r_sc} * {6'd0, i_cfg.image_height};

    // counter chain, innermost is the output column
    logic       w_wrap_oc, w_wrap_or, w_wrap_kc, w_wrap_kr, w_wrap_sc;
    logic [7:0] n_ocol, n_orow;
    logic [3:0] n_kcol, n_krow;
    logic [5:0] n_sc;

    always_comb begin
        w_wrap_oc = ({1'b0, r_ocol} + 9'd1) >= {1'b0, w_lim_oc};
        w_wrap_or = ({1'b0, r_orow} + 9'd1) >= {1'b0, w_lim_or};
        w_wrap_kc = ({1'b0, r_kcol} + 5'd1) >= {1'b0, w_lim_kc};
        w_wrap_kr = ({1'b0, r_krow} + 5'd1) >= {1'b0, w_lim_kr};
        w_wrap_sc = ({1'b0, r_sc} + 7'd1) >= w_effc;
        n_ocol = w_wrap_oc ? 8'd0 : r_ocol + 8'd1;
        n_orow = r_orow;
        n_kcol = r_kcol;
        n_krow = r_krow;
        n_sc   = r_sc;
        if (w_wrap_oc) begin
            n_orow = w_wrap_or ? 8'd0 : r_orow + 8'd1;
            if (w_wrap_or) begin
                n_kcol = w_wrap_kc ? 4'd0 : r_kcol + 4'd1;
                if (w_wrap_kc) begin
                    n_krow = w_wrap_kr ? 4'd0 : r_krow + 4'd1;
                    if (w_wrap_kr) begin
                        n_sc = w_wrap_sc ? 6'd0 : r_sc + 6'd1;
                    end
                end
            end
        end
    end

    // address stages
    logic        w_inr;
    logic [14:0] w_base;
    logic [23:0] w_lin;
    logic        w_hit;

    assign w_inr  = !r_row[13] && (r_row[12:0] < {5'd0, i_cfg.image_height}) &&
                    !r_col[13] && (r_col[12:0] < {5'd0, i_cfg.image_width});
    assign w_base = {1'b0, r_chh} + {7'd0, r_row[7:0]};
    assign w_lin  = {9'd0, r_base} * {16'd0, i_cfg.image_width} + {16'd0, r_col[7:0]};
    assign w_hit  = r_inr && (r_lin < 24'(IMAGE_WORDS));

    // drain entry selection
    logic [14:0]   w_cw;
    logic [22:0]   w_total;
    logic [PW-1:0] w_count, w_last, w_pick, n_ptr;
    logic          w_zero, w_end;

    assign w_cw    = {8'd0, w_effc} * {7'd0, i_cfg.image_height};
    assign w_total = {8'd0, r_cw} * {15'd0, i_cfg.image_width};

    always_comb begin
        w_zero  = (r_total == 23'd0);
        w_count = (r_total >= 23'(IMAGE_WORDS)) ? PW'(IMAGE_WORDS) : PW'(r_total);
        w_last  = w_count - PW'(1);
        // an empty image never marks an end; its pointer runs up, then keeps to the top entry
        w_end   = !w_zero && (r_ptr >= w_last);
        if (w_end) begin
            w_pick = w_last;
        end else if (r_ptr >= PW'(IMAGE_WORDS)) begin
            w_pick = PW'(IMAGE_WORDS - 1);
        end else begin
            w_pick = r_ptr;
        end
        n_ptr = w_end ? '0 : w_pick + PW'(1);
    end

    // saturating add
    logic signed [XW-1:0] w_sum;
    logic [SUM_BITS-1:0]  w_sat;

    always_comb begin
        w_sum = XW'($signed(r_rd_data)) + XW'($signed(r_sample));
        if (w_sum > SUM_MAX) begin
            w_sat = SUM_MAX[SUM_BITS-1:0];
        end else if (w_sum < SUM_MIN) begin
            w_sat = SUM_MIN[SUM_BITS-1:0];
        end else begin
            w_sat = w_sum[SUM_BITS-1:0];
        end
    end

    // store port selection
    logic                w_out_free;
    logic                w_emit;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [SUM_BITS-1:0] w_wr_data;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = i_cmd.drn_emit && w_out_free;

    always_comb begin
        w_rd_en   = (i_cmd.acc_read && w_hit) || i_cmd.drn_read;
        w_rd_addr = i_cmd.drn_read ? r_p : r_lin[AW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr;
        w_wr_data = '0;
        if (i_cmd.clr) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.acc_write && r_hit) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_lin[AW-1:0];
            w_wr_data = w_sat;
        end else if (w_emit) begin
            // an entry read out is left cleared
            w_wr_en   = 1'b1;
            w_wr_addr = r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_sc        <= '0;
            r_krow      <= '0;
            r_kcol      <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.acc_map) begin
                r_sc   <= n_sc;
                r_krow <= n_krow;
                r_kcol <= n_kcol;
                r_orow <= n_orow;
                r_ocol <= n_ocol;
            end
            if (i_cmd.drn_pick) begin
                r_ptr <= n_ptr;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.acc_map) begin
            r_row <= w_row;
            r_col <= w_col;
            r_chh <= w_chh;
        end
        if (i_cmd.acc_base) begin
            r_inr  <= w_inr;
            r_base <= w_base;
        end
        if (i_cmd.acc_addr) begin
            r_lin <= w_lin;
        end
        if (i_cmd.acc_read) begin
            r_hit <= w_hit;
        end
        if (i_cmd.drn_prod) begin
            r_cw <= w_cw;
        end
        if (i_cmd.drn_total) begin
            r_total <= w_total;
        end
        if (i_cmd.drn_pick) begin
            r_p   <= w_pick[AW-1:0];
            r_end <= w_end;
        end
        if (w_emit) begin
            r_out_data <= r_rd_data;
            r_out_last <= r_end;
        end
    end

    assign o_sts.clr_done = (r_clr == AW'(IMAGE_WORDS - 1));
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_out_last     = r_out_last;

endmodule
